// ===== rtl/core/nsrl_pkg.sv =====
// package: shared types and constants for the relaxation limiter
`default_nettype none
package nsrl_pkg;
	localparam int unsigned MaxStationsDef = 1024;
	localparam logic [30:0] UpperResetVal = 31'h6000_0000;
	localparam logic [31:0] LowerResetVal = 32'hE000_0000;
	localparam logic [31:0] RelaxOne = 32'h4000_0000;
	localparam logic [62:0] SumMax = {63{1'b1}};
	localparam logic [31:0] RatioMax = 32'h7FFF_FFFF;

	localparam logic [1:0] RegUpper = 2'd0;
	localparam logic [1:0] RegLower = 2'd1;
	localparam logic [1:0] RegTrans = 2'd2;

	typedef struct packed {
		logic        first;
		logic        last;
		logic        laminar;
		logic [31:0] start_rel;
		logic [31:0] cf;
		logic [31:0] dcf;
		logic [31:0] th;
		logic [31:0] dth;
		logic [31:0] ds;
		logic [31:0] dds;
		logic [31:0] due;
	} item_t;

	typedef enum logic [3:0] {
		B_IDLE, B_DIV, B_TRACK, B_LIM_P, B_LIM_N, B_OUT
	} bstate_t;
endpackage
`default_nettype wire

// ===== rtl/core/nsrl_div.sv =====
// iterative signed divider: 64-bit dividend by 64-bit divisor, one bit per cycle
`default_nettype none
module nsrl_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [63:0] den,
	output logic                    done,
	output logic signed [63:0]      quo
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        neg_q, busy_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[63] ? 64'(-num) : num;
			den_q <= den[63] ? 64'(-den) : den;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? 64'(-quo_q) : quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/nsrl_front.sv =====
// front end: accepts stations, tags laminar stations, feeds a two-entry queue
`default_nettype none
module nsrl_front #(
	parameter int unsigned MAX_STATIONS = nsrl_pkg::MaxStationsDef
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire nsrl_pkg::item_t      in_item,
	input  wire logic [10:0]          trans,
	output logic                      q_valid,
	input  wire logic                 q_ready,
	output nsrl_pkg::item_t           q_item
);
	localparam int unsigned IdxW = $clog2(MAX_STATIONS + 1);

	nsrl_pkg::item_t buf_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] idx_use;
	logic            push, pop;
	nsrl_pkg::item_t tagged_item;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = buf_q[rp_q];
	assign idx_use  = in_item.first ? '0 : idx_q;

	always_comb begin
		tagged_item = in_item;
		tagged_item.laminar = (32'(idx_use) < 32'(trans));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				if (32'(idx_use) < MAX_STATIONS)
					idx_q <= idx_use + IdxW'(1);
				else
					idx_q <= idx_use;
			end
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= tagged_item;
	end
endmodule
`default_nettype wire

// ===== rtl/core/nsrl_back.sv =====
// back end: forms the normalized changes, tracks metrics and limits relaxation
`default_nettype none
module nsrl_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire nsrl_pkg::item_t   q_item,
	input  wire logic [30:0]       upper,
	input  wire logic [31:0]       lower,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            out_rel,
	output logic [62:0]            out_sum,
	output logic [30:0]            out_max,
	output logic                   out_sat
);
	nsrl_pkg::bstate_t st_q, st_d;
	nsrl_pkg::item_t   it_q;
	logic [1:0]        k_q;
	logic signed [31:0] gp_q, mn_q, dn_q;
	logic [62:0]       sum_q;
	logic [31:0]       rel_q;
	logic              sat_q;

	logic              dv_start, dv_done;
	logic signed [63:0] dv_num, dv_den, dv_quo;
	logic signed [31:0] num_s, den_s, due_s, mag_s;
	logic              use_div;
	logic signed [63:0] clamp_v;
	logic [31:0]       dmag;
	logic [63:0]       sq, sum_ext;
	logic [32:0]       negmn;
	logic              div_run_q;
	logic              go_div;
	logic              lam_sel;
	logic [31:0]       dcf_mag;
	logic [56:0]       lam_prod;
	logic signed [31:0] lam_v;

	nsrl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	always_comb begin
		num_s = it_q.dcf;
		den_s = it_q.cf;
		unique case (k_q)
			2'd0: begin
				num_s = it_q.dcf;
				den_s = it_q.cf;
			end
			2'd1: begin
				num_s = it_q.dth;
				den_s = it_q.th;
			end
			2'd2: begin
				num_s = it_q.dds;
				den_s = it_q.ds;
			end
			default: begin
				num_s = it_q.dcf;
				den_s = it_q.cf;
			end
		endcase
	end

	// laminar friction change: divide by 1280 as a shift by 8 and a multiply by 1/5
	assign lam_sel  = (k_q == 2'd0) && it_q.laminar;
	assign dcf_mag  = it_q.dcf[31] ? 32'd0 - it_q.dcf : it_q.dcf;
	assign lam_prod = 57'(dcf_mag[31:8]) * 57'h0_CCCC_CCCD;
	assign lam_v    = it_q.dcf[31] ? -signed'({9'd0, lam_prod[56:34]}) :
		signed'({9'd0, lam_prod[56:34]});

	assign due_s   = it_q.due;
	assign mag_s   = 32'((due_s[31] ? -{due_s[31], due_s} : {1'b0, due_s}) >> 5);
	assign use_div = (k_q != 2'd3) && !lam_sel && (den_s != 32'sd0);
	assign clamp_v = dv_quo;

	always_comb begin
		dv_num = 64'(signed'(num_s)) <<< 23;
		dv_den = 64'(signed'(den_s));
		if (st_q == nsrl_pkg::B_LIM_P) begin
			dv_num = {10'd0, upper, 23'd0};
			dv_den = 64'(signed'(gp_q));
		end else if (st_q == nsrl_pkg::B_LIM_N) begin
			dv_num = 64'(signed'(lower)) <<< 23;
			dv_den = 64'(signed'(mn_q));
		end
	end

	assign dmag    = dn_q[31] ? 32'(-dn_q) : dn_q;
	assign sq      = 64'(dmag) * 64'(dmag);
	assign sum_ext = {1'b0, sum_q};
	assign negmn   = 33'(-(33'(signed'(mn_q))));

	assign go_div = !div_run_q && (
		(st_q == nsrl_pkg::B_DIV && use_div) ||
		(st_q == nsrl_pkg::B_LIM_P && gp_q > 0) ||
		(st_q == nsrl_pkg::B_LIM_N && mn_q < 0));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			nsrl_pkg::B_IDLE:  if (q_valid) st_d = nsrl_pkg::B_DIV;
			nsrl_pkg::B_DIV:   if (!use_div || dv_done) st_d = nsrl_pkg::B_TRACK;
			nsrl_pkg::B_TRACK: begin
				if (k_q != 2'd3) st_d = nsrl_pkg::B_DIV;
				else if (!it_q.last) st_d = nsrl_pkg::B_IDLE;
				else st_d = nsrl_pkg::B_LIM_P;
			end
			nsrl_pkg::B_LIM_P: if (gp_q <= 0 || dv_done) st_d = nsrl_pkg::B_LIM_N;
			nsrl_pkg::B_LIM_N: if (mn_q >= 0 || dv_done) st_d = nsrl_pkg::B_OUT;
			nsrl_pkg::B_OUT:   if (!out_valid) st_d = nsrl_pkg::B_IDLE;
			default: st_d = nsrl_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_ready  = (st_q == nsrl_pkg::B_IDLE);
		dv_start = go_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= nsrl_pkg::B_IDLE;
			k_q       <= '0;
			gp_q      <= '0;
			mn_q      <= '0;
			sum_q     <= '0;
			rel_q     <= nsrl_pkg::RelaxOne;
			sat_q     <= 1'b0;
			out_valid <= 1'b0;
			div_run_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (go_div)
				div_run_q <= 1'b1;
			else if (dv_done)
				div_run_q <= 1'b0;
			unique case (st_q)
				nsrl_pkg::B_IDLE: begin
					k_q <= '0;
					if (q_valid && q_item.first) begin
						gp_q  <= '0;
						mn_q  <= '0;
						sum_q <= '0;
						sat_q <= 1'b0;
						rel_q <= q_item.start_rel;
					end
				end
				nsrl_pkg::B_DIV: begin
					if (k_q == 2'd3) begin
						dn_q <= mag_s;
					end else if (lam_sel) begin
						dn_q <= lam_v;
					end else if (!use_div) begin
						sat_q <= 1'b1;
						dn_q <= num_s[31] ? -signed'(nsrl_pkg::RatioMax) :
							(num_s == 0 ? 32'sd0 : signed'(nsrl_pkg::RatioMax));
					end else if (dv_done) begin
						if (clamp_v > 64'sd2147483647) begin
							dn_q <= signed'(nsrl_pkg::RatioMax);
							sat_q <= 1'b1;
						end else if (clamp_v < -64'sd2147483647) begin
							dn_q <= -signed'(nsrl_pkg::RatioMax);
							sat_q <= 1'b1;
						end else
							dn_q <= 32'(clamp_v);
					end
				end
				nsrl_pkg::B_TRACK: begin
					k_q <= k_q + 2'd1;
					if (dn_q > gp_q) gp_q <= dn_q;
					if (dn_q < mn_q) mn_q <= dn_q;
					if (sq > 64'(nsrl_pkg::SumMax) - sum_ext) begin
						sum_q <= nsrl_pkg::SumMax;
						sat_q <= 1'b1;
					end else
						sum_q <= 63'(sum_ext + sq);
				end
				nsrl_pkg::B_LIM_P: begin
					if (dv_done && dv_quo < 64'(rel_q))
						rel_q <= dv_quo[31:0];
				end
				nsrl_pkg::B_LIM_N: begin
					if (dv_done) begin
						if (dv_quo < 0) begin
							sat_q <= 1'b1;
							rel_q <= '0;
						end else if (dv_quo < 64'(rel_q))
							rel_q <= dv_quo[31:0];
					end
				end
				nsrl_pkg::B_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_rel   <= rel_q;
						out_sum   <= sum_q;
						out_max   <= (32'(gp_q) > negmn[31:0]) ? gp_q[30:0] : negmn[30:0];
						out_sat   <= sat_q;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == nsrl_pkg::B_IDLE && q_valid)
			it_q <= q_item;
	end
endmodule
`default_nettype wire

// ===== rtl/core/newton_step_relaxation_limiter_core.sv =====
// top level: newton step relaxation limiter
`default_nettype none
// Usage: one boundary-layer station per input item on a valid/ready channel.
// first_station clears the metrics and loads start_relaxation; after the
// item with last_station set, one result (relaxation, sum_of_squares,
// max_change, saturated) appears on the output valid/ready channel.
// A front stage accepts items into a two-entry queue and marks laminar
// stations by their index; a back stage forms the three data-dependent
// quotients through one shared radix-2 divider that resolves one quotient
// bit per cycle, and the laminar friction change by a shift and a
// reciprocal multiply. The back stage works on one station at a time,
// while the queue can take further stations; a last station adds up to
// two more divisions, for the upper and lower limits.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once; the
// user is to make them while the block is idle; the block does not check.
// Reset: limits return to 1.5 and -0.5, transition station to 0, the
// running relaxation to 1.0 and all metrics to zero.
// A stalled receiver holds the result register; the back stage waits and
// the queue then fills, after which in_ready drops.
module newton_step_relaxation_limiter_core #(
	parameter int unsigned MAX_STATIONS = nsrl_pkg::MaxStationsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        first_station,
	input  wire logic        last_station,
	input  wire logic [31:0] start_relaxation,
	input  wire logic signed [31:0] skin_friction,
	input  wire logic signed [31:0] skin_friction_change,
	input  wire logic signed [31:0] momentum_thickness,
	input  wire logic signed [31:0] momentum_change,
	input  wire logic signed [31:0] displacement_thickness,
	input  wire logic signed [31:0] displacement_change,
	input  wire logic signed [31:0] edge_velocity_change,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      relaxation,
	output logic [62:0]      sum_of_squares,
	output logic [30:0]      max_change,
	output logic             saturated,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data
);
	logic [30:0] upper_q;
	logic [31:0] lower_q;
	logic [10:0] trans_q;
	nsrl_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= nsrl_pkg::UpperResetVal;
			lower_q <= nsrl_pkg::LowerResetVal;
			trans_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				nsrl_pkg::RegUpper: upper_q <= wr_data[30:0];
				nsrl_pkg::RegLower: lower_q <= wr_data;
				nsrl_pkg::RegTrans: trans_q <= wr_data[10:0];
				default: trans_q <= trans_q;
			endcase
		end
	end

	always_comb begin
		in_item.first     = first_station;
		in_item.last      = last_station;
		in_item.laminar   = 1'b0;
		in_item.start_rel = start_relaxation;
		in_item.cf        = skin_friction;
		in_item.dcf       = skin_friction_change;
		in_item.th        = momentum_thickness;
		in_item.dth       = momentum_change;
		in_item.ds        = displacement_thickness;
		in_item.dds       = displacement_change;
		in_item.due       = edge_velocity_change;
	end

	nsrl_front #(.MAX_STATIONS(MAX_STATIONS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.trans(trans_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	nsrl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.upper(upper_q), .lower(lower_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_rel(relaxation), .out_sum(sum_of_squares),
		.out_max(max_change), .out_sat(saturated)
	);
endmodule
`default_nettype wire

// ===== tb/sv/relaxation_checker.sv =====
// checker: predicts relaxation limiter results from the observed channels and compares them
module relaxation_checker #(
	parameter int unsigned MAX_STATIONS = nsrl_pkg::MaxStationsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               first_station,
	input  logic               last_station,
	input  logic [31:0]        start_relaxation,
	input  logic signed [31:0] skin_friction,
	input  logic signed [31:0] skin_friction_change,
	input  logic signed [31:0] momentum_thickness,
	input  logic signed [31:0] momentum_change,
	input  logic signed [31:0] displacement_thickness,
	input  logic signed [31:0] displacement_change,
	input  logic signed [31:0] edge_velocity_change,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        relaxation,
	input  logic [62:0]        sum_of_squares,
	input  logic [30:0]        max_change,
	input  logic               saturated,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	output int                 errors,
	output int                 pending,
	output int                 results_checked
);
	typedef longint unsigned u64_t;

	typedef struct {
		logic [31:0] rel;
		logic [62:0] sos;
		logic [30:0] mx;
		logic        sat;
	} limit_result_t;

	localparam longint RatioLimit = 64'sd2147483647;
	localparam u64_t   SquareLimit = 64'h7FFF_FFFF_FFFF_FFFF;

	limit_result_t expected_results[$];

	u64_t        upper_lim;
	longint      lower_lim;
	int unsigned trans_station;
	int unsigned st_index;
	longint      gpos;
	longint      mneg;
	u64_t        sq_acc;
	u64_t        run_rel;
	bit          sat_flag;

	assign pending = expected_results.size();

	function automatic longint norm_ratio(longint num, longint den);
		longint q;
		if (den == 0) begin
			sat_flag = 1'b1;
			return num > 0 ? RatioLimit : (num < 0 ? -RatioLimit : 64'sd0);
		end
		q = (num * 64'sd8388608) / den;
		if (q > RatioLimit) begin
			sat_flag = 1'b1;
			return RatioLimit;
		end
		if (q < -RatioLimit) begin
			sat_flag = 1'b1;
			return -RatioLimit;
		end
		return q;
	endfunction

	function automatic void accumulate(longint dn);
		u64_t mag;
		u64_t sq;
		mag = u64_t'(dn < 0 ? -dn : dn);
		sq = mag * mag;
		if (dn > gpos) gpos = dn;
		if (dn < mneg) mneg = dn;
		if (sq > SquareLimit - sq_acc) begin
			sq_acc = SquareLimit;
			sat_flag = 1'b1;
		end else begin
			sq_acc = sq_acc + sq;
		end
	endfunction

	function automatic void predict_station();
		longint        cf, dcf, due, lq, neg, mx;
		u64_t          rel, uq;
		limit_result_t r;
		cf = skin_friction;
		dcf = skin_friction_change;
		due = edge_velocity_change;
		if (first_station) begin
			st_index = 0;
			gpos = 0;
			mneg = 0;
			sq_acc = 0;
			sat_flag = 1'b0;
			run_rel = u64_t'(start_relaxation);
		end
		if (st_index < trans_station) accumulate(dcf / 64'sd1280);
		else accumulate(norm_ratio(dcf, cf));
		accumulate(norm_ratio(longint'(momentum_change), longint'(momentum_thickness)));
		accumulate(norm_ratio(longint'(displacement_change),
			longint'(displacement_thickness)));
		accumulate((due < 0 ? -due : due) / 64'sd32);
		if (st_index < MAX_STATIONS) st_index++;
		if (!last_station) return;
		rel = run_rel;
		if (gpos > 0) begin
			uq = (upper_lim * 64'd8388608) / u64_t'(gpos);
			if (uq < rel) rel = uq;
		end
		if (mneg < 0) begin
			lq = (lower_lim * 64'sd8388608) / mneg;
			if (lq < 0) begin
				lq = 0;
				sat_flag = 1'b1;
			end
			if (u64_t'(lq) < rel) rel = u64_t'(lq);
		end
		run_rel = rel & 64'hFFFF_FFFF;
		neg = -mneg;
		mx = gpos > neg ? gpos : neg;
		r.rel = rel[31:0];
		r.sos = sq_acc[62:0];
		r.mx = mx[30:0];
		r.sat = sat_flag;
		expected_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		limit_result_t e;
		if (!arst_n) begin
			upper_lim <= u64_t'(nsrl_pkg::UpperResetVal);
			lower_lim <= longint'(signed'(nsrl_pkg::LowerResetVal));
			trans_station <= 0;
			st_index <= 0;
			gpos <= 0;
			mneg <= 0;
			sq_acc <= 0;
			run_rel <= u64_t'(nsrl_pkg::RelaxOne);
			sat_flag <= 1'b0;
			errors <= 0;
			results_checked <= 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				results_checked <= results_checked + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result rel=%h sos=%h max=%h sat=%b", $time,
						relaxation, sum_of_squares, max_change, saturated);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					if (e.rel !== relaxation || e.sos !== sum_of_squares ||
					    e.mx !== max_change || e.sat !== saturated) begin
						$display("%0t: mismatch expected rel=%h sos=%h max=%h sat=%b", $time,
							e.rel, e.sos, e.mx, e.sat);
						$display("%0t:          actual rel=%h sos=%h max=%h sat=%b", $time,
							relaxation, sum_of_squares, max_change, saturated);
						errors <= errors + 1;
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					nsrl_pkg::RegUpper: upper_lim = u64_t'(wr_data[30:0]);
					nsrl_pkg::RegLower: lower_lim = longint'(signed'(wr_data));
					nsrl_pkg::RegTrans: trans_station = int'(wr_data[10:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_station();
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// testbench top: stimulus, configuration phases and verdict for the relaxation limiter
module testbench;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               first_station = 1'b0;
	logic               last_station = 1'b0;
	logic [31:0]        start_relaxation = '0;
	logic signed [31:0] skin_friction = '0;
	logic signed [31:0] skin_friction_change = '0;
	logic signed [31:0] momentum_thickness = '0;
	logic signed [31:0] momentum_change = '0;
	logic signed [31:0] displacement_thickness = '0;
	logic signed [31:0] displacement_change = '0;
	logic signed [31:0] edge_velocity_change = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        relaxation;
	logic [62:0]        sum_of_squares;
	logic [30:0]        max_change;
	logic               saturated;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = nsrl_pkg::RegUpper;
	logic [31:0]        wr_data = '0;

	int errors, pending, results_checked;
	int stations_sent = 0;
	int ready_hold = 0;
	bit no_gaps = 1'b0;

	always #5 clk = ~clk;

	newton_step_relaxation_limiter_core uut (.*);

	relaxation_checker chk (.*);

	// receiver stalls: mostly short, now and then long
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (no_gaps) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= $urandom_range(0, 3) != 0;
			ready_hold <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 3);
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4, 5: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	task automatic send_station(input logic f, input logic l, input logic [31:0] sr,
		input logic [31:0] cf, input logic [31:0] dcf, input logic [31:0] th,
		input logic [31:0] dth, input logic [31:0] ds, input logic [31:0] dds,
		input logic [31:0] due);
		int gap;
		in_valid <= 1'b1;
		first_station <= f;
		last_station <= l;
		start_relaxation <= sr;
		skin_friction <= cf;
		skin_friction_change <= dcf;
		momentum_thickness <= th;
		momentum_change <= dth;
		displacement_thickness <= ds;
		displacement_change <= dds;
		edge_velocity_change <= due;
		do @(posedge clk); while (!in_ready);
		stations_sent++;
		gap = $urandom_range(0, 9);
		gap = no_gaps ? 0 : (gap < 6 ? 0 : (gap < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_station(input logic f, input logic l);
		send_station(f, l, $urandom_range(0, 32'h8000_0000), pick_value(), pick_value(),
			pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
	endtask

	task automatic random_segment(input int n, input bit with_first);
		for (int i = 0; i < n; i++) random_station(with_first && i == 0, i == n - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_limits(input logic [30:0] up, input logic [31:0] lo,
		input logic [10:0] trans);
		wr_en <= 1'b1;
		wr_index <= nsrl_pkg::RegUpper;
		wr_data <= {1'b0, up};
		@(posedge clk);
		wr_index <= nsrl_pkg::RegLower;
		wr_data <= lo;
		@(posedge clk);
		wr_index <= nsrl_pkg::RegTrans;
		wr_data <= {21'd0, trans};
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int items);
		int n;
		n = 0;
		while (n < items) begin
			int len;
			len = $urandom_range(0, 19) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 5);
			no_gaps = $urandom_range(0, 5) == 0;
			random_segment(len, $urandom_range(0, 9) != 0);
			n += len;
		end
		no_gaps = 1'b0;
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stations after reset with no first station
		send_station(0, 0, 0, 32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'hFF00_0000,
			32'h0400_0000, 32'h0100_0000, 32'h0000_1000);
		send_station(0, 1, 0, 32'h0100_0000, 32'hFFC0_0000, 32'h0200_0000, 32'h0100_0000,
			32'h0400_0000, 32'hFE00_0000, 32'hFFFF_0000);
		// one-station segments at the extremes
		send_station(1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_station(1, 1, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_station(1, 1, 32'h4000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
		// zero divisors with positive, negative and zero numerators
		send_station(1, 0, 32'h4000_0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_0000,
			32'hFFFF_F000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_station(0, 1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		// continuing past a result with no first station
		send_station(0, 0, 0, 32'h4000_0000, 32'h0100_0000, 32'h4000_0000, 32'hFF00_0000,
			32'h4000_0000, 32'h0000_0100, 32'h0100_0000);
		send_station(0, 1, 0, 32'h4000_0000, 32'h0200_0000, 32'h4000_0000, 32'hF000_0000,
			32'h4000_0000, 32'h0000_0100, 32'h8000_0000);
		drain();

		// laminar stations at the start of a segment
		set_limits(31'h7FFF_FFFF, 32'h8000_0000, 11'd3);
		random_segment(6, 1);
		random_segment(4, 1);
		drain();
		set_limits(31'h0000_0000, 32'h0000_0000, 11'd0);
		random_segment(3, 1);
		random_segment(2, 1);
		drain();

		// station index runs past its limit in one long segment
		set_limits(31'h2000_0000, 32'hF000_0000, 11'd1024);
		no_gaps = 1'b1;
		random_segment(1030, 1);
		no_gaps = 1'b0;
		drain();

		random_phase(10);
		set_limits(31'h7FFF_FFFF, 32'h8000_0000, 11'd2);
		random_phase(10);
		set_limits(31'h0000_0000, 32'h0000_0000, 11'd0);
		random_phase(10);
		set_limits($urandom, -$signed({1'b0, $urandom_range(0, 32'h7FFF_FFFF)}),
			$urandom_range(0, 1024));
		random_phase(10);
		set_limits(nsrl_pkg::UpperResetVal, nsrl_pkg::LowerResetVal, 11'd1);
		random_phase(10);

		$display("stations sent: %0d, results checked: %0d", stations_sent, results_checked);
		$display("covered extremes, zero divisors, laminar stations, index limit and five limit settings");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
